// File: hw/rtl/i2cseq_pkg.sv
// Shared types, codes and helpers of the I2C register transaction sequencer.
package i2cseq_pkg;

   // Request opcodes.
   localparam logic [1:0] OP_READ  = 2'd0;
   localparam logic [1:0] OP_WRITE = 2'd1;
   localparam logic [1:0] OP_EVENT = 2'd2;

   // Result kinds.
   localparam logic [1:0] KIND_CMD  = 2'd0;
   localparam logic [1:0] KIND_DATA = 2'd1;
   localparam logic [1:0] KIND_DONE = 2'd2;

   // Engine commands.
   localparam logic [2:0] CMD_START = 3'd0;
   localparam logic [2:0] CMD_SEND  = 3'd1;
   localparam logic [2:0] CMD_RACK  = 3'd2;
   localparam logic [2:0] CMD_RNACK = 3'd3;
   localparam logic [2:0] CMD_STOP  = 3'd4;

   // Engine status codes, compared after masking off the low three bits.
   localparam logic [7:0] ST_MASK     = 8'hF8;
   localparam logic [7:0] ST_START    = 8'h08;
   localparam logic [7:0] ST_RESTART  = 8'h10;
   localparam logic [7:0] ST_SLAW_ACK = 8'h18;
   localparam logic [7:0] ST_SLAR_ACK = 8'h40;
   localparam logic [7:0] ST_DATA_ACK = 8'h28;

   // Most result words one input word can cause.
   localparam int MAX_RESULTS = 3;

   typedef enum logic [7:0] {
      PH_IDLE   = 8'b0000_0001,
      PH_START1 = 8'b0000_0010,
      PH_SLAW   = 8'b0000_0100,
      PH_REG    = 8'b0000_1000,
      PH_VAL    = 8'b0001_0000,
      PH_START2 = 8'b0010_0000,
      PH_SLAR   = 8'b0100_0000,
      PH_READ   = 8'b1000_0000
   } phase_type;

   typedef struct packed {
      logic [1:0] opcode;
      logic [6:0] dev_addr;
      logic [7:0] reg_addr;
      logic [7:0] write_value;
      logic [7:0] read_length;
      logic [7:0] engine_status;
      logic [7:0] engine_data;
   } req_word_type;

   typedef struct packed {
      logic [1:0] kind;
      logic [2:0] command;
      logic [7:0] command_byte;
      logic [7:0] data_byte;
      logic [7:0] byte_index;
      logic       success;
      logic       last;
   } rsp_word_type;

   typedef struct packed {
      phase_type  phase;
      logic [6:0] saved_device;
      logic [7:0] saved_register;
      logic [7:0] saved_value;
      logic [7:0] total_length;
      logic [7:0] bytes_done;
      logic       is_write;
   } seq_state_type;

   // Result words of one step, oldest in entry zero.
   typedef struct packed {
      logic [1:0]              count;
      rsp_word_type [MAX_RESULTS-1:0] words;
   } step_out_type;

   // Load request from the control path into the result queue.
   typedef struct packed {
      logic                    load;
      logic [1:0]              count;
      rsp_word_type [MAX_RESULTS-1:0] words;
   } queue_load_type;

   // Fill level of the result queue.
   typedef struct packed {
      logic [1:0] count;
   } queue_status_type;

   function automatic rsp_word_type mk_word(input logic [1:0] kind,
                                            input logic [2:0] command,
                                            input logic [7:0] command_byte,
                                            input logic [7:0] data_byte,
                                            input logic [7:0] byte_index,
                                            input logic       success);
      rsp_word_type w;
      w.kind         = kind;
      w.command      = command;
      w.command_byte = command_byte;
      w.data_byte    = data_byte;
      w.byte_index   = byte_index;
      w.success      = success;
      w.last         = 1'b0;
      return w;
   endfunction

endpackage

// File: hw/rtl/i2cseq_step.sv
// Next-state and result logic for one request or engine completion word.
module i2cseq_step
   import i2cseq_pkg::*;
(
   input  seq_state_type cur_state,
   input  req_word_type  req,
   output seq_state_type next_state,
   output step_out_type  step_out
);

   logic [7:0] status;
   logic [7:0] done_inc;
   logic [2:0] first_read_cmd;
   logic [2:0] next_read_cmd;
   logic       status_ok;

   always_comb begin
      status   = req.engine_status & ST_MASK;
      done_inc = cur_state.bytes_done + 8'd1;
      // With nothing read yet, ack only if more than one byte is wanted.
      first_read_cmd = (9'd1 < {1'b0, cur_state.total_length}) ? CMD_RACK : CMD_RNACK;
      next_read_cmd  = ({1'b0, done_inc} + 9'd1 < {1'b0, cur_state.total_length}) ?
                       CMD_RACK : CMD_RNACK;
      status_ok = 1'b0;

      next_state     = cur_state;
      step_out       = '0;

      case (req.opcode)
         OP_READ, OP_WRITE: begin
            if (cur_state.phase == PH_IDLE) begin
               next_state.saved_device   = req.dev_addr;
               next_state.saved_register = req.reg_addr;
               next_state.saved_value    = req.write_value;
               next_state.total_length   = req.read_length;
               next_state.bytes_done     = 8'd0;
               next_state.is_write       = req.opcode[0];
               next_state.phase          = PH_START1;
               step_out.words[0] = mk_word(KIND_CMD, CMD_START, 8'd0, 8'd0, 8'd0, 1'b0);
               step_out.count    = 2'd1;
            end
         end
         OP_EVENT: begin
            unique case (cur_state.phase)
               PH_IDLE: begin
               end
               PH_START1, PH_START2: begin
                  if (status == ST_START || status == ST_RESTART) begin
                     step_out.words[0] = mk_word(KIND_CMD, CMD_SEND,
                        {cur_state.saved_device, cur_state.phase == PH_START2},
                        8'd0, 8'd0, 1'b0);
                     step_out.count   = 2'd1;
                     next_state.phase = (cur_state.phase == PH_START2) ? PH_SLAR : PH_SLAW;
                  end else begin
                     step_out.count = 2'd2;
                  end
               end
               PH_SLAW: begin
                  if (status == ST_SLAW_ACK) begin
                     step_out.words[0] = mk_word(KIND_CMD, CMD_SEND,
                        cur_state.saved_register, 8'd0, 8'd0, 1'b0);
                     step_out.count   = 2'd1;
                     next_state.phase = PH_REG;
                  end else begin
                     step_out.count = 2'd2;
                  end
               end
               PH_REG: begin
                  if (status != ST_DATA_ACK) begin
                     step_out.count = 2'd2;
                  end else if (cur_state.is_write) begin
                     step_out.words[0] = mk_word(KIND_CMD, CMD_SEND,
                        cur_state.saved_value, 8'd0, 8'd0, 1'b0);
                     step_out.count   = 2'd1;
                     next_state.phase = PH_VAL;
                  end else begin
                     step_out.words[0] = mk_word(KIND_CMD, CMD_START,
                        8'd0, 8'd0, 8'd0, 1'b0);
                     step_out.count   = 2'd1;
                     next_state.phase = PH_START2;
                  end
               end
               PH_VAL: begin
                  status_ok      = (status == ST_DATA_ACK);
                  step_out.count = 2'd2;
               end
               PH_SLAR: begin
                  if (status != ST_SLAR_ACK) begin
                     step_out.count = 2'd2;
                  end else if (cur_state.total_length == 8'd0) begin
                     status_ok      = 1'b1;
                     step_out.count = 2'd2;
                  end else begin
                     next_state.bytes_done = 8'd0;
                     step_out.words[0] = mk_word(KIND_CMD, first_read_cmd,
                        8'd0, 8'd0, 8'd0, 1'b0);
                     step_out.count   = 2'd1;
                     next_state.phase = PH_READ;
                  end
               end
               PH_READ: begin
                  // Received bytes carry no status check.
                  next_state.bytes_done = done_inc;
                  step_out.words[0] = mk_word(KIND_DATA, CMD_START, 8'd0,
                     req.engine_data, cur_state.bytes_done, 1'b0);
                  if (done_inc >= cur_state.total_length) begin
                     status_ok      = 1'b1;
                     step_out.count = 2'd3;
                  end else begin
                     step_out.words[1] = mk_word(KIND_CMD, next_read_cmd,
                        8'd0, 8'd0, 8'd0, 1'b0);
                     step_out.count = 2'd2;
                  end
               end
               default: begin
                  next_state.phase = PH_IDLE;
               end
            endcase
         end
         default: begin
         end
      endcase

      // Ending a transaction: a stop command, then the finished report.
      if (req.opcode == OP_EVENT && next_state.phase == cur_state.phase &&
          cur_state.phase != PH_IDLE && cur_state.phase != PH_READ) begin
         step_out.words[0] = mk_word(KIND_CMD, CMD_STOP, 8'd0, 8'd0, 8'd0, 1'b0);
         step_out.words[1] = mk_word(KIND_DONE, CMD_START, 8'd0, 8'd0, 8'd0, status_ok);
         next_state.phase  = PH_IDLE;
      end else if (req.opcode == OP_EVENT && cur_state.phase == PH_READ &&
                   step_out.count == 2'd3) begin
         step_out.words[1] = mk_word(KIND_CMD, CMD_STOP, 8'd0, 8'd0, 8'd0, 1'b0);
         step_out.words[2] = mk_word(KIND_DONE, CMD_START, 8'd0, 8'd0, 8'd0, 1'b1);
         next_state.phase  = PH_IDLE;
      end

      case (step_out.count)
         2'd1:    step_out.words[0].last = 1'b1;
         2'd2:    step_out.words[1].last = 1'b1;
         2'd3:    step_out.words[2].last = 1'b1;
         default: begin
         end
      endcase
   end

endmodule

// File: hw/rtl/i2cseq_rsp_queue.sv
// Result buffer that holds the words of one step and hands them out in order.
module i2cseq_rsp_queue
   import i2cseq_pkg::*;
(
   input  logic             clock,
   input  logic             reset,
   input  queue_load_type   q_load,
   output queue_status_type q_status,
   output logic             rsp_valid,
   input  logic             rsp_ready,
   output rsp_word_type     rsp_word
);

   logic [1:0]                     count_ff, count_in;
   rsp_word_type [MAX_RESULTS-1:0] words_ff, words_in;
   logic                           pop;

   assign rsp_valid      = (count_ff != 2'd0);
   assign pop            = rsp_valid && rsp_ready;
   assign rsp_word       = words_ff[0];
   assign q_status.count = count_ff;

   // A load only comes when the buffer is empty after this cycle's pop.
   always_comb begin
      count_in = count_ff;
      words_in = words_ff;
      if (q_load.load) begin
         count_in = q_load.count;
         words_in = q_load.words;
      end else if (pop) begin
         count_in    = count_ff - 2'd1;
         words_in[0] = words_ff[1];
         words_in[1] = words_ff[2];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= 2'd0;
      end else begin
         count_ff <= count_in;
      end
      words_ff <= words_in;
   end

endmodule

// File: hw/rtl/i2c_register_transaction_sequencer_core.sv
// Top level of the I2C register transaction sequencer.
// An accepted word waits in the input register until the result buffer can take its results.
// Throughput: one input word per cycle while each causes at most one result word and the
// output is ready; a word that causes more holds the single result port until all are taken.
// Reset: synchronous, active high; clears the transaction state to idle and
// empties the input register and the result buffer.
module i2c_register_transaction_sequencer_core
   import i2cseq_pkg::*;
(
   input  logic         clock,
   input  logic         reset,
   input  logic         req_valid,
   output logic         req_ready,
   input  req_word_type req_word,
   output logic         rsp_valid,
   input  logic         rsp_ready,
   output rsp_word_type rsp_word
);

   // The input register holds one accepted word. It is processed against
   // the transaction state in a single pass of combinational logic, and
   // all of the words it causes (at most three) are loaded into the result
   // buffer at once. The word moves on as soon as the buffer will be empty
   // at the end of the cycle, so a new request or completion word can be
   // taken every cycle while each causes at most one result and output keeps up.

   logic             in_valid_ff, in_valid_in;
   req_word_type     in_word_ff, in_word_in;
   seq_state_type    state_ff, state_in;
   seq_state_type    step_state;
   step_out_type     step_out;
   queue_load_type   q_load;
   queue_status_type q_status;
   logic             advance;
   logic             req_take;

   i2cseq_step u_step (
      .cur_state  (state_ff),
      .req        (in_word_ff),
      .next_state (step_state),
      .step_out   (step_out)
   );

   // The buffer is free for new words when it is empty, or when its last
   // word leaves in this very cycle.
   assign advance = in_valid_ff &&
                    ((q_status.count == 2'd0) ||
                     (q_status.count == 2'd1 && rsp_ready));

   assign req_ready = !in_valid_ff || advance;
   assign req_take  = req_valid && req_ready;

   assign q_load.load  = advance;
   assign q_load.count = step_out.count;
   assign q_load.words = step_out.words;

   i2cseq_rsp_queue u_rsp_queue (
      .clock     (clock),
      .reset     (reset),
      .q_load    (q_load),
      .q_status  (q_status),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_word  (rsp_word)
   );

   always_comb begin
      in_valid_in = in_valid_ff;
      in_word_in  = in_word_ff;
      state_in    = state_ff;
      if (advance) begin
         in_valid_in = 1'b0;
         state_in    = step_state;
      end
      if (req_take) begin
         in_valid_in = 1'b1;
         in_word_in  = req_word;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff             <= 1'b0;
         state_ff.phase          <= PH_IDLE;
         state_ff.saved_device   <= 7'd0;
         state_ff.saved_register <= 8'd0;
         state_ff.saved_value    <= 8'd0;
         state_ff.total_length   <= 8'd0;
         state_ff.bytes_done     <= 8'd0;
         state_ff.is_write       <= 1'b0;
      end else begin
         in_valid_ff <= in_valid_in;
         state_ff    <= state_in;
      end
      in_word_ff <= in_word_in;
   end

`ifndef SYNTH
   // The buffer never holds more words than one step can cause.
   a_queue_bound: assert property (@(posedge clock) disable iff (reset)
      q_status.count <= 2'd3)
      else $error("result buffer holds more than three words");

   // A step that causes results shows them in the next cycle.
   a_load_shows: assert property (@(posedge clock) disable iff (reset)
      advance && step_out.count != 2'd0 |=> rsp_valid)
      else $error("loaded results not presented");

   // The last flag marks exactly the final buffered word of a step.
   a_last_mark: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_word.last == (q_status.count == 2'd1)))
      else $error("last flag on the wrong result word");

   // The input register never drops a word while the buffer is busy.
   a_hold_input: assert property (@(posedge clock) disable iff (reset)
      in_valid_ff && !advance |=> in_valid_ff && $stable(in_word_ff))
      else $error("pending input word lost");
`endif

endmodule
